[hdl/mme_pkg.sv]
// ----------------------------------------------------------------------------
// Matrix multiply engine package
// Shared constants, command and tag types, and helper functions.
// ----------------------------------------------------------------------------
package mme_pkg;

    localparam int MAX_DIM     = 8;
    localparam int IDX_W       = 3;
    localparam int DIM_W       = 4;
    localparam int VAL_W       = 16;
    localparam int PROD_W      = 2 * VAL_W;
    localparam int ACC_W       = 35;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COLS     = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CMD_WRITE_A,
        CMD_WRITE_B,
        CMD_COMPUTE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                 kind;
        logic [ADDR_W-1:0]         addr;
        logic signed [VAL_W-1:0]   value;
    } t_cmd;

    typedef struct packed {
        logic [IDX_W-1:0] row_last;
        logic [IDX_W-1:0] inner_last;
        logic [IDX_W-1:0] col_last;
    } t_dims;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             first;
        logic             sum_done;
        logic             last;
    } t_tag;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_seq_state;

    function automatic logic [IDX_W-1:0] clamp_last(input logic [DIM_W-1:0] v);
        logic [IDX_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (v > DIM_W'(MAX_DIM)) begin
            res = IDX_W'(MAX_DIM - 1);
        end else begin
            res = IDX_W'(v - 1'b1);
        end
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                    input logic [IDX_W-1:0] col);
        return ADDR_W'(int'(row) * MAX_DIM + int'(col));
    endfunction

endpackage

[hdl/matrix_multiply_engine_unit.sv]
// ----------------------------------------------------------------------------
// Matrix multiply engine
// Loads A and B elements and emits the product matrix in row-major order.
//
//   Channel  Handshake                 Payload
//   in       i_in_valid / o_in_ready   i_op, i_row_index, i_col_index,
//                                      i_element_value
//   out      o_out_valid / i_out_ready o_out_row, o_out_col,
//                                      o_product_value, o_last
//   cfg      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A write item is performed by the idle back end as it leaves the queue; a
// compute item starts a run of a_rows * b_cols * inner_size multiply-accumulates.
// Each result passes through the store read, product and output registers.
// A four-entry command queue decouples the two ends; a stalled output freezes
// the whole multiply pipeline. Reset clears the control state and sets all
// three dimensions to eight; the element stores are not cleared.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [mme_pkg::OP_W-1:0]            i_op,
    input  logic [mme_pkg::IDX_W-1:0]           i_row_index,
    input  logic [mme_pkg::IDX_W-1:0]           i_col_index,
    input  logic signed [mme_pkg::VAL_W-1:0]    i_element_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [mme_pkg::IDX_W-1:0]           o_out_row,
    output logic [mme_pkg::IDX_W-1:0]           o_out_col,
    output logic signed [mme_pkg::ACC_W-1:0]    o_product_value,
    output logic                                o_last,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mme_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mme_pkg::DIM_W-1:0]           i_cfg_data
);

    logic [mme_pkg::DIM_W-1:0] r_a_rows;
    logic [mme_pkg::DIM_W-1:0] r_inner_size;
    logic [mme_pkg::DIM_W-1:0] r_b_cols;

    mme_pkg::t_dims dims;
    mme_pkg::t_cmd  cmd;
    logic           cmd_valid;
    logic           cmd_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows     <= mme_pkg::DIM_RESET;
            r_inner_size <= mme_pkg::DIM_RESET;
            r_b_cols     <= mme_pkg::DIM_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mme_pkg::CFG_A_ROWS: begin
                    r_a_rows <= i_cfg_data;
                end
                mme_pkg::CFG_INNER_SIZE: begin
                    r_inner_size <= i_cfg_data;
                end
                mme_pkg::CFG_B_COLS: begin
                    r_b_cols <= i_cfg_data;
                end
                default: begin
                    r_a_rows <= r_a_rows;
                end
            endcase
        end
    end

    always_comb begin
        dims.row_last   = mme_pkg::clamp_last(r_a_rows);
        dims.inner_last = mme_pkg::clamp_last(r_inner_size);
        dims.col_last   = mme_pkg::clamp_last(r_b_cols);
    end

    mme_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_element_value (i_element_value),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd),
        .i_cmd_pop       (cmd_pop)
    );

    mme_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dims          (dims),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (cmd),
        .o_cmd_pop       (cmd_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_product_value (o_product_value),
        .o_last          (o_last)
    );

endmodule

[hdl/mme_front.sv]
// ----------------------------------------------------------------------------
// Matrix multiply engine front end
// Accepts input items, drops unused codes and out-of-range writes, and queues
// the remaining commands for the back end.
// ----------------------------------------------------------------------------
module mme_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [mme_pkg::OP_W-1:0]           i_op,
    input  logic [mme_pkg::IDX_W-1:0]          i_row_index,
    input  logic [mme_pkg::IDX_W-1:0]          i_col_index,
    input  logic signed [mme_pkg::VAL_W-1:0]   i_element_value,
    output logic                               o_cmd_valid,
    output mme_pkg::t_cmd                      o_cmd,
    input  logic                               i_cmd_pop
);

    mme_pkg::t_cmd                 r_queue [mme_pkg::QUEUE_DEPTH];
    logic [mme_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [mme_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [mme_pkg::QPTR_W:0]      r_count;
    logic [mme_pkg::QPTR_W:0]      n_count;

    logic          accept;
    logic          in_range;
    logic          push;
    mme_pkg::t_cmd new_cmd;

    assign o_in_ready = (r_count != (mme_pkg::QPTR_W + 1)'(mme_pkg::QUEUE_DEPTH));
    assign accept     = i_in_valid && o_in_ready;
    assign in_range   = ({1'b0, i_row_index} < (mme_pkg::IDX_W + 1)'(mme_pkg::MAX_DIM))
                     && ({1'b0, i_col_index} < (mme_pkg::IDX_W + 1)'(mme_pkg::MAX_DIM));

    always_comb begin
        new_cmd.addr  = mme_pkg::elem_addr(i_row_index, i_col_index);
        new_cmd.value = i_element_value;
        new_cmd.kind  = mme_pkg::CMD_COMPUTE;
        push          = 1'b0;
        case (mme_pkg::t_op'(i_op))
            mme_pkg::OP_WRITE_A: begin
                new_cmd.kind = mme_pkg::CMD_WRITE_A;
                push         = accept && in_range;
            end
            mme_pkg::OP_WRITE_B: begin
                new_cmd.kind = mme_pkg::CMD_WRITE_B;
                push         = accept && in_range;
            end
            mme_pkg::OP_COMPUTE: begin
                new_cmd.kind = mme_pkg::CMD_COMPUTE;
                push         = accept;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (push && !i_cmd_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_cmd_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= new_cmd;
        end
    end

    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];

endmodule

[hdl/mme_back.sv]
// ----------------------------------------------------------------------------
// Matrix multiply engine back end
// Holds the A and B stores, performs element writes, and runs the
// multiply-accumulate pipeline that produces the product in row-major order.
// ----------------------------------------------------------------------------
module mme_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mme_pkg::t_dims                     i_dims,
    input  logic                               i_cmd_valid,
    input  mme_pkg::t_cmd                      i_cmd,
    output logic                               o_cmd_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [mme_pkg::IDX_W-1:0]          o_out_row,
    output logic [mme_pkg::IDX_W-1:0]          o_out_col,
    output logic signed [mme_pkg::ACC_W-1:0]   o_product_value,
    output logic                               o_last
);

    logic signed [mme_pkg::VAL_W-1:0] a_mem [mme_pkg::STORE_DEPTH];
    logic signed [mme_pkg::VAL_W-1:0] b_mem [mme_pkg::STORE_DEPTH];

    mme_pkg::t_seq_state r_state;
    mme_pkg::t_seq_state n_state;

    logic [mme_pkg::IDX_W-1:0] r_i;
    logic [mme_pkg::IDX_W-1:0] r_j;
    logic [mme_pkg::IDX_W-1:0] r_k;

    logic signed [mme_pkg::VAL_W-1:0]  r_a_rd;
    logic signed [mme_pkg::VAL_W-1:0]  r_b_rd;
    logic                              r_s1_vld;
    mme_pkg::t_tag                     r_s1_tag;
    logic signed [mme_pkg::PROD_W-1:0] r_prod;
    logic                              r_s2_vld;
    mme_pkg::t_tag                     r_s2_tag;
    logic signed [mme_pkg::ACC_W-1:0]  r_acc;
    logic signed [mme_pkg::ACC_W-1:0]  n_acc;

    logic                              r_out_valid;
    logic [mme_pkg::IDX_W-1:0]         r_out_row;
    logic [mme_pkg::IDX_W-1:0]         r_out_col;
    logic signed [mme_pkg::ACC_W-1:0]  r_out_value;
    logic                              r_out_last;

    logic advance;
    logic we_a;
    logic we_b;
    logic start;
    logic issue;
    logic k_end;
    logic j_end;
    logic i_end;
    logic at_end;
    logic [mme_pkg::ADDR_W-1:0] rd_addr_a;
    logic [mme_pkg::ADDR_W-1:0] rd_addr_b;
    mme_pkg::t_tag issue_tag;

    assign advance = !r_out_valid || i_out_ready;
    assign k_end   = (r_k == i_dims.inner_last);
    assign j_end   = (r_j == i_dims.col_last);
    assign i_end   = (r_i == i_dims.row_last);
    assign at_end  = k_end && j_end && i_end;

    always_comb begin
        n_state = r_state;
        case (r_state)
            mme_pkg::ST_IDLE: begin
                if (i_cmd_valid && (i_cmd.kind == mme_pkg::CMD_COMPUTE)) begin
                    n_state = mme_pkg::ST_RUN;
                end
            end
            mme_pkg::ST_RUN: begin
                if (advance && at_end) begin
                    n_state = mme_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mme_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        we_a      = 1'b0;
        we_b      = 1'b0;
        start     = 1'b0;
        issue     = 1'b0;
        case (r_state)
            mme_pkg::ST_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                we_a      = i_cmd_valid && (i_cmd.kind == mme_pkg::CMD_WRITE_A);
                we_b      = i_cmd_valid && (i_cmd.kind == mme_pkg::CMD_WRITE_B);
                start     = i_cmd_valid && (i_cmd.kind == mme_pkg::CMD_COMPUTE);
            end
            mme_pkg::ST_RUN: begin
                issue = advance;
            end
            default: begin
                issue = 1'b0;
            end
        endcase
    end

    assign rd_addr_a = mme_pkg::elem_addr(r_i, r_k);
    assign rd_addr_b = mme_pkg::elem_addr(r_k, r_j);

    always_comb begin
        issue_tag.row      = r_i;
        issue_tag.col      = r_j;
        issue_tag.first    = (r_k == '0);
        issue_tag.sum_done = k_end;
        issue_tag.last     = at_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mme_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
        end else if (issue) begin
            if (k_end) begin
                r_k <= '0;
                if (j_end) begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end else begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_a) begin
            a_mem[i_cmd.addr] <= i_cmd.value;
        end
        if (advance) begin
            r_a_rd <= a_mem[rd_addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_b) begin
            b_mem[i_cmd.addr] <= i_cmd.value;
        end
        if (advance) begin
            r_b_rd <= b_mem[rd_addr_b];
        end
    end

    always_comb begin
        n_acc = (r_s2_tag.first ? '0 : r_acc) + mme_pkg::ACC_W'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_vld    <= issue;
            r_s2_vld    <= r_s1_vld;
            r_out_valid <= r_s2_vld && r_s2_tag.sum_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_tag <= issue_tag;
            r_s2_tag <= r_s1_tag;
            r_prod   <= mme_pkg::PROD_W'(r_a_rd) * mme_pkg::PROD_W'(r_b_rd);
            if (r_s2_vld) begin
                r_acc <= n_acc;
            end
            r_out_row   <= r_s2_tag.row;
            r_out_col   <= r_s2_tag.col;
            r_out_value <= n_acc;
            r_out_last  <= r_s2_tag.last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_product_value = r_out_value;
    assign o_last          = r_out_last;

endmodule
